// ----- rtl/core/lscl_pkg.sv -----
package lscl_pkg;

  localparam int CACHE_SLOTS = 128;
  localparam int KEY_BITS    = 16;
  localparam int STAMP_W     = 32;
  localparam int IDX_W       = $clog2(CACHE_SLOTS);
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 7;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_SLOTS - 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INVAL  = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_INVAL   = 3'd2,
    ST_NOMATCH = 3'd3,
    ST_FLUSH   = 3'd4
  } status_e_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // One RAM word per slot: stored key and its use stamp
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [STAMP_W-1:0]  stamp;
  } slot_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_scan;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/lscl_req_if.sv -----
interface lscl_req_if;
  logic                              valid;
  logic                              ready;
  logic [lscl_pkg::REQ_W-1:0]    req_type;
  logic [lscl_pkg::KEY_BITS-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

// ----- rtl/core/lscl_rsp_if.sv -----
interface lscl_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [lscl_pkg::STATUS_W-1:0] status;
  logic [lscl_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

// ----- rtl/core/lscl_ram.sv -----
module lscl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/lscl_ctrl.sv -----
module lscl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  lscl_pkg::sts_t   sts,
  output lscl_pkg::cmd_t   cmd
);

  lscl_pkg::state_t state;
  lscl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lscl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lscl_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = sts.needs_scan ? lscl_pkg::S_SCAN : lscl_pkg::S_DONE;
        end
      end
      lscl_pkg::S_SCAN: begin
        if (sts.scan_end) begin
          state_next = lscl_pkg::S_DONE;
        end
      end
      lscl_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_next = lscl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lscl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready    = 1'b0;
    cmd.load     = 1'b0;
    cmd.scan     = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      lscl_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      lscl_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      lscl_pkg::S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // hold the result state until the output register frees up
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == lscl_pkg::S_DONE && !sts.out_free) |=> state == lscl_pkg::S_DONE)
    else $error("result dropped while output register full");

  // a scan only ends through its end condition
  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    (state == lscl_pkg::S_SCAN && !sts.scan_end) |=> state == lscl_pkg::S_SCAN)
    else $error("scan left early");

endmodule

// ----- rtl/core/lscl_dp.sv -----
module lscl_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  lscl_pkg::cmd_t                    cmd,
  output lscl_pkg::sts_t                    sts,
  input  logic [lscl_pkg::REQ_W-1:0]    req_type,
  input  logic [lscl_pkg::KEY_BITS-1:0] key,
  input  logic                              rsp_ready,
  output logic                              rsp_valid,
  output logic [lscl_pkg::STATUS_W-1:0] status,
  output logic [lscl_pkg::SLOT_W-1:0]   slot
);

  lscl_pkg::req_e_t                  req_q;
  logic [lscl_pkg::KEY_BITS-1:0]     key_q;
  logic [lscl_pkg::STAMP_W-1:0]      counter;
  logic [lscl_pkg::CACHE_SLOTS-1:0]  slot_valid;

  logic [lscl_pkg::IDX_W-1:0]        rd_addr;
  logic                              rd_more;
  logic                              cmp_vld;
  logic [lscl_pkg::IDX_W-1:0]        cmp_idx;
  logic [lscl_pkg::STAMP_W-1:0]      best;
  logic [lscl_pkg::IDX_W-1:0]        victim;

  lscl_pkg::status_e_t               res_status;
  logic [lscl_pkg::SLOT_W-1:0]       res_slot;

  lscl_pkg::slot_word_t              rdata;
  lscl_pkg::slot_word_t              wdata;
  logic                              ram_we;
  logic                              ram_re;
  logic [lscl_pkg::IDX_W-1:0]        ram_waddr;

  logic                              entry_valid;
  logic [lscl_pkg::STAMP_W-1:0]      eff_stamp;
  logic                              take;
  logic [lscl_pkg::STAMP_W-1:0]      best_next;
  logic [lscl_pkg::IDX_W-1:0]        victim_next;
  logic                              match;
  logic                              scan_end;
  logic                              is_lookup;

  lscl_ram #(
    .WIDTH ($bits(lscl_pkg::slot_word_t)),
    .DEPTH (lscl_pkg::CACHE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // an empty slot reads as stamp zero, whatever the RAM holds
  always_comb begin
    entry_valid = slot_valid[cmp_idx];
    eff_stamp   = entry_valid ? rdata.stamp : '0;
    take        = (cmp_idx == '0) || (eff_stamp < best);
    best_next   = take ? eff_stamp : best;
    victim_next = take ? cmp_idx : victim;
    match       = entry_valid && (rdata.key == key_q);
    scan_end    = cmd.scan && cmp_vld && (match || (cmp_idx == lscl_pkg::LAST_IDX));
    is_lookup   = (req_q == lscl_pkg::REQ_LOOKUP);
    ram_re      = cmd.scan && rd_more;
    ram_we      = scan_end && is_lookup;
    ram_waddr   = match ? cmp_idx : victim_next;
    wdata.key   = key_q;
    wdata.stamp = counter;
  end

  always_comb begin
    sts.needs_scan = (req_type == lscl_pkg::REQ_LOOKUP) || (req_type == lscl_pkg::REQ_INVAL);
    sts.scan_end   = scan_end;
    sts.out_free   = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter    <= '0;
      slot_valid <= '0;
      rd_more    <= 1'b0;
      cmp_vld    <= 1'b0;
    end else if (cmd.load) begin
      rd_more <= 1'b1;
      cmp_vld <= 1'b0;
      if (req_type == lscl_pkg::REQ_LOOKUP) begin
        counter <= counter + 1'b1;
      end
      if (req_type == lscl_pkg::REQ_FLUSH) begin
        counter    <= '0;
        slot_valid <= '0;
      end
    end else if (cmd.scan) begin
      cmp_vld <= rd_more;
      if (rd_more && rd_addr == lscl_pkg::LAST_IDX) begin
        rd_more <= 1'b0;
      end
      if (ram_we) begin
        slot_valid[ram_waddr] <= 1'b1;
      end else if (scan_end && match) begin
        slot_valid[cmp_idx] <= 1'b0;
      end
    end
  end

  // scan payload: request, read address, compare tag, running minimum, result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= lscl_pkg::req_e_t'(req_type);
      key_q   <= key;
      rd_addr <= '0;
      unique case (lscl_pkg::req_e_t'(req_type))
        lscl_pkg::REQ_FLUSH: begin
          res_status <= lscl_pkg::ST_FLUSH;
          res_slot   <= '0;
        end
        lscl_pkg::REQ_RSVD: begin
          res_status <= lscl_pkg::ST_NOMATCH;
          res_slot   <= '0;
        end
        default: begin
          res_slot <= '0;
        end
      endcase
    end else if (cmd.scan) begin
      cmp_idx <= rd_addr;
      if (rd_more) begin
        rd_addr <= rd_addr + 1'b1;
      end
      if (cmp_vld) begin
        best   <= best_next;
        victim <= victim_next;
      end
      if (scan_end) begin
        priority if (match) begin
          res_status <= is_lookup ? lscl_pkg::ST_HIT : lscl_pkg::ST_INVAL;
          res_slot   <= lscl_pkg::SLOT_W'(cmp_idx);
        end else if (is_lookup) begin
          res_status <= lscl_pkg::ST_MISS;
          res_slot   <= lscl_pkg::SLOT_W'(victim_next);
        end else begin
          res_status <= lscl_pkg::ST_NOMATCH;
          res_slot   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= res_status;
      slot   <= res_slot;
    end
  end

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && req_type == lscl_pkg::REQ_FLUSH) |=> (counter == '0 && slot_valid == '0))
    else $error("flush left state behind");

  a_claim_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> slot_valid[$past(ram_waddr)])
    else $error("claimed or stamped slot not valid");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && req_type == lscl_pkg::REQ_LOOKUP)
      |=> counter == lscl_pkg::STAMP_W'($past(counter) + 1'b1))
    else $error("use counter did not advance on lookup");

endmodule

// ----- rtl/core/lru_slot_cache_lookup_top.sv -----
// LRU slot cache lookup: fully associative, 128 slots, timestamp replacement.
//
// Channels: req carries one request (req_type, key); rsp returns exactly one
// result (status, slot) per request, in order. Both use valid/ready; a
// transfer happens on a rising edge with valid and ready high.
// Request codes: lookup, invalidate key, flush, and an unused code that
// answers "no match" and changes nothing.
//
// Timing: one request at a time. Lookups and invalidates scan the slot RAM
// one entry per cycle (one read port), up to the first match or the last
// of the 128 slots. A miss scans all slots. Flush and the unused code skip
// the scan. The next request can be taken from the cycle after the result
// moves into the output register.
//
// Reset (rst, synchronous) empties every slot and zeroes the use counter;
// slot keys and stamps in RAM need no clearing. While rsp.ready is
// low a result waits in the output register; a new request is still taken
// and worked on, and its result is held back until the register frees.
module lru_slot_cache_lookup_top (
  input  logic              clk,
  input  logic              rst,
  lscl_req_if.sink          req,
  lscl_rsp_if.source        rsp
);

  lscl_pkg::cmd_t cmd;
  lscl_pkg::sts_t sts;

  // sequence: accept, scan, hand result over
  lscl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot RAM, valid bits, use counter, victim search and output register
  lscl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_type  (req.req_type),
    .key       (req.key),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .status    (rsp.status),
    .slot      (rsp.slot)
  );

endmodule
